// ===== hdl/assert_macros.svh =====
// Assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ===== hdl/wfbm_pkg.sv =====
// Shared constants, types and stage offsets for the tree placement pipeline
package wfbm_pkg;

    localparam int COORD_BITS      = 12;
    localparam int NOISE_FRAC_BITS = 16;
    localparam int POS_FRAC        = 16;
    localparam int DIVISOR_W       = 13;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int BYTE_W          = 8;
    localparam int REASON_W        = 3;

    // position and divider widths
    localparam int NUM_W      = COORD_BITS + POS_FRAC;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;
    localparam int POS_W      = NUM_W + 10;
    localparam int WX_W       = NUM_W + 2;

    // noise value widths
    localparam int NV_W   = NOISE_FRAC_BITS;
    localparam int EASE_W = POS_FRAC + 1;
    localparam int ACC_W  = NV_W + 4;

    // reciprocal division of the octave sum by 2^n-1
    localparam int RECIP_SHIFT = ACC_W + 6;
    localparam logic [RECIP_SHIFT-1:0] RECIP3  =
        RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
    localparam logic [RECIP_SHIFT-1:0] RECIP7  =
        RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd6) / 64'd7);
    localparam logic [RECIP_SHIFT-1:0] RECIP15 =
        RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);

    // hash constants
    localparam logic [31:0] HASH_KX = 32'd374761;
    localparam logic [31:0] HASH_KY = 32'd668265;
    localparam logic [31:0] HASH_KS = 32'd2246822;
    localparam logic [31:0] HASH_KM = 32'd1274126177;

    // seed offsets
    localparam logic [31:0] SEED_STEP   = 32'd100;
    localparam logic [31:0] SEED_WARP_X = 32'd100;
    localparam logic [31:0] SEED_WARP_Y = 32'd200;
    localparam logic [31:0] SEED_LARGE  = 32'd500;
    localparam logic [31:0] SEED_MED    = 32'd600;
    localparam logic [31:0] SEED_FINE   = 32'd700;
    localparam logic [31:0] SEED_PLACE  = 32'd999;

    // warp and layer scaling
    localparam int WARP_SH   = 3;
    localparam int WARP_GAIN = 3932;
    localparam int WARP_HALF = 1 << (NOISE_FRAC_BITS - 1);
    localparam int LAYER_LARGE = 14;
    localparam int LAYER_MED   = 35;
    localparam int LAYER_FINE  = 70;
    localparam int W_LARGE   = 26214;
    localparam int W_MED     = 22938;
    localparam int W_FINE    = 16384;
    localparam int MIX_SHIFT = 16;

    // density
    localparam logic [NV_W:0] NOISE_ONE = (NV_W+1)'(1) << NOISE_FRAC_BITS;
    localparam logic [NV_W-1:0] NOISE_T0 =
        NV_W'((7 * (64'd1 << NOISE_FRAC_BITS)) / 20);

    // climate and height rules
    localparam logic [BYTE_W-1:0] ELEV_MIN   = 8'd110;
    localparam logic [BYTE_W-1:0] ELEV_MAX   = 8'd204;
    localparam logic [BYTE_W-1:0] CLIM_BAND1 = 8'd86;
    localparam logic [BYTE_W-1:0] CLIM_BAND2 = 8'd172;

    typedef enum logic [REASON_W-1:0] {
        REASON_PLACED  = 3'd0,
        REASON_WATER   = 3'd1,
        REASON_HEIGHT  = 3'd2,
        REASON_BIOME   = 3'd3,
        REASON_DENSITY = 3'd4
    } t_reason;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED       = 2'd0,
        CFG_MAP_WIDTH  = 2'd1,
        CFG_MAP_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OCT_2 = 2'd0,
        OCT_3 = 2'd1,
        OCT_4 = 2'd2
    } t_oct;

    // unit latencies and stage positions after the input register
    localparam int HASH_LAT = 4;
    localparam int VN_LAT   = 7;
    localparam int FBM_LAT  = 2;
    localparam int L_NX     = DIV_STAGES;
    localparam int L_WVN    = L_NX + VN_LAT;
    localparam int L_WFBM   = L_WVN + FBM_LAT;
    localparam int L_WX     = L_WFBM + 1;
    localparam int L_SCALE  = L_WX + 1;
    localparam int L_LVN    = L_SCALE + VN_LAT;
    localparam int L_LFBM   = L_LVN + FBM_LAT;
    localparam int L_MIX    = L_LFBM + 1;
    localparam int L_CLAMP  = L_MIX + 1;
    localparam int L_SQ     = L_CLAMP + 1;
    localparam int L_DENS   = L_SQ + 1;
    localparam int NX_DLY   = L_WFBM - L_NX;

endpackage

// ===== hdl/wfbm_div.sv =====
// Pipelined restoring divider: (num << 16) / den, four quotient bits per stage
module wfbm_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [wfbm_pkg::COORD_BITS-1:0] i_num,
    input  logic [wfbm_pkg::DIVISOR_W-1:0]  i_den,
    output logic [wfbm_pkg::NUM_W-1:0]      o_quo
);
    import wfbm_pkg::*;

    logic [DIVISOR_W-1:0] r_rem [DIV_STAGES];
    logic [NUM_W-1:0]     r_quo [DIV_STAGES];
    logic [DIVISOR_W-1:0] n_rem [DIV_STAGES];
    logic [NUM_W-1:0]     n_quo [DIV_STAGES];

    always_comb begin
        logic [DIVISOR_W:0]   t;
        logic [DIVISOR_W-1:0] rem;
        logic [NUM_W-1:0]     q;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = '0;
                q   = {i_num, {POS_FRAC{1'b0}}};
            end else begin
                rem = r_rem[s-1];
                q   = r_quo[s-1];
            end
            // shift a dividend bit into the remainder, keep quotient bits below
            for (int k = 0; k < DIV_STEPS; k++) begin
                t = {rem, q[NUM_W-1]};
                q = {q[NUM_W-2:0], 1'b0};
                if (t >= {1'b0, i_den}) begin
                    t    = t - {1'b0, i_den};
                    q[0] = 1'b1;
                end
                rem = t[DIVISOR_W-1:0];
            end
            n_rem[s] = rem;
            n_quo[s] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// ===== hdl/wfbm_hash.sv =====
// Four-stage integer hash of a lattice point and a seed
module wfbm_hash (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_sd,
    output logic [31:0] o_hash
);
    import wfbm_pkg::*;

    logic [31:0] r_px;
    logic [31:0] r_py;
    logic [31:0] r_ps;
    logic [31:0] r_mix;
    logic [31:0] r_prod;
    logic [31:0] r_hash;
    logic [31:0] sum;

    assign sum = r_px + r_py + r_ps;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= i_x * HASH_KX;
            r_py   <= i_y * HASH_KY;
            r_ps   <= i_sd * HASH_KS;
            r_mix  <= sum ^ (sum >> 13);
            r_prod <= r_mix * HASH_KM;
            r_hash <= r_prod ^ (r_prod >> 16);
        end
    end

    assign o_hash = r_hash;

endmodule

// ===== hdl/wfbm_vnoise.sv =====
// Value noise sample: lattice hashes, smoothstep weights and bilinear blend
module wfbm_vnoise (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [wfbm_pkg::POS_W-1:0] i_px,
    input  logic signed [wfbm_pkg::POS_W-1:0] i_py,
    input  logic [31:0]                      i_sd,
    output logic [wfbm_pkg::NV_W-1:0]        o_value
);
    import wfbm_pkg::*;

    function automatic logic [POS_FRAC-1:0] ease_sq(input logic [POS_FRAC-1:0] f);
        logic [2*POS_FRAC-1:0] p;
        p = f * f;
        return p[2*POS_FRAC-1:POS_FRAC];
    endfunction

    function automatic logic [EASE_W-1:0] ease_poly(input logic [POS_FRAC-1:0] f2,
                                                    input logic [POS_FRAC-1:0] f);
        logic [POS_FRAC+1:0]          k;
        logic [2*POS_FRAC+1:0]        p;
        k = (POS_FRAC+2)'(3) << POS_FRAC;
        k = k - {1'b0, f, 1'b0};
        p = f2 * k;
        return p[POS_FRAC +: EASE_W];
    endfunction

    // a + floor((b - a) * s / 2^16)
    function automatic logic [NV_W-1:0] lerp(input logic [NV_W-1:0] a,
                                             input logic [NV_W-1:0] b,
                                             input logic [EASE_W-1:0] s);
        logic signed [NV_W:0]          d;
        logic signed [NV_W+EASE_W+1:0] p;
        logic signed [NV_W+EASE_W+1:0] r;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, s});
        r = $signed((NV_W+EASE_W+2)'(a)) + (p >>> POS_FRAC);
        return r[NV_W-1:0];
    endfunction

    logic signed [POS_W-1:0] sh_x;
    logic signed [POS_W-1:0] sh_y;

    logic [31:0]          r_ix, r_ix1, r_iy, r_iy1, r_sd;
    logic [POS_FRAC-1:0]  r_fx, r_fy, r_fx2, r_fy2, r_fx_d, r_fy_d;
    logic [EASE_W-1:0]    r_sx3, r_sy3, r_sx4, r_sy4, r_sx5, r_sy5, r_sy6;
    logic [NV_W-1:0]      r_a, r_b, r_val;
    logic [31:0]          h00, h10, h01, h11;

    assign sh_x = i_px >>> POS_FRAC;
    assign sh_y = i_py >>> POS_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ix   <= 32'(sh_x);
            r_ix1  <= 32'(sh_x) + 32'd1;
            r_iy   <= 32'(sh_y);
            r_iy1  <= 32'(sh_y) + 32'd1;
            r_sd   <= i_sd;
            r_fx   <= i_px[POS_FRAC-1:0];
            r_fy   <= i_py[POS_FRAC-1:0];
            r_fx2  <= ease_sq(r_fx);
            r_fy2  <= ease_sq(r_fy);
            r_fx_d <= r_fx;
            r_fy_d <= r_fy;
            r_sx3  <= ease_poly(r_fx2, r_fx_d);
            r_sy3  <= ease_poly(r_fy2, r_fy_d);
            // hold the weights until the hashes arrive
            r_sx4  <= r_sx3;
            r_sy4  <= r_sy3;
            r_sx5  <= r_sx4;
            r_sy5  <= r_sy4;
            r_a    <= lerp(h00[31 -: NV_W], h10[31 -: NV_W], r_sx5);
            r_b    <= lerp(h01[31 -: NV_W], h11[31 -: NV_W], r_sx5);
            r_sy6  <= r_sy5;
            r_val  <= lerp(r_a, r_b, r_sy6);
        end
    end

    wfbm_hash u_h00 (.i_clk(i_clk), .i_en(i_en), .i_x(r_ix),  .i_y(r_iy),
                     .i_sd(r_sd), .o_hash(h00));
    wfbm_hash u_h10 (.i_clk(i_clk), .i_en(i_en), .i_x(r_ix1), .i_y(r_iy),
                     .i_sd(r_sd), .o_hash(h10));
    wfbm_hash u_h01 (.i_clk(i_clk), .i_en(i_en), .i_x(r_ix),  .i_y(r_iy1),
                     .i_sd(r_sd), .o_hash(h01));
    wfbm_hash u_h11 (.i_clk(i_clk), .i_en(i_en), .i_x(r_ix1), .i_y(r_iy1),
                     .i_sd(r_sd), .o_hash(h11));

    assign o_value = r_val;

endmodule

// ===== hdl/wfbm_fbm.sv =====
// Octave weighting and division of the weighted sum by 2^n-1
module wfbm_fbm (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  wfbm_pkg::t_oct            i_oct,
    input  logic [wfbm_pkg::NV_W-1:0] i_noise [4],
    output logic [wfbm_pkg::NV_W-1:0] o_value
);
    import wfbm_pkg::*;

    logic [ACC_W-1:0]             n_acc;
    logic [ACC_W-1:0]             r_acc;
    t_oct                         r_oct;
    logic [RECIP_SHIFT-1:0]       recip;
    logic [ACC_W+RECIP_SHIFT-1:0] r_prod;
    logic [ACC_W-1:0]             e0, e1, e2, e3;

    assign e0 = ACC_W'(i_noise[0]);
    assign e1 = ACC_W'(i_noise[1]);
    assign e2 = ACC_W'(i_noise[2]);
    assign e3 = ACC_W'(i_noise[3]);

    always_comb begin
        case (i_oct)
            OCT_2:   n_acc = (e0 << 1) + e1;
            OCT_3:   n_acc = (e0 << 2) + (e1 << 1) + e2;
            OCT_4:   n_acc = (e0 << 3) + (e1 << 2) + (e2 << 1) + e3;
            default: n_acc = '0;
        endcase
    end

    always_comb begin
        case (r_oct)
            OCT_2:   recip = RECIP3;
            OCT_3:   recip = RECIP7;
            OCT_4:   recip = RECIP15;
            default: recip = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_oct  <= i_oct;
            r_prod <= r_acc * recip;
        end
    end

    assign o_value = r_prod[RECIP_SHIFT +: NV_W];

endmodule

// ===== hdl/warped_fbm_tree_placement.sv =====
// Top level of the tree placement pipeline
// Throughput: one cell per cycle; the whole pipeline holds while a result waits.
// The divider stages and the two value-noise passes set the depth.
// Reset (synchronous, active low) empties the pipeline and sets seed 0, map 4096x4096.
module warped_fbm_tree_placement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [wfbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wfbm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [wfbm_pkg::COORD_BITS-1:0]   i_cell_x,
    input  logic [wfbm_pkg::COORD_BITS-1:0]   i_cell_y,
    input  logic [wfbm_pkg::BYTE_W-1:0]       i_elevation,
    input  logic [wfbm_pkg::BYTE_W-1:0]       i_moisture,
    input  logic [wfbm_pkg::BYTE_W-1:0]       i_temperature,
    input  logic                              i_land_flag,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_spawn_tree,
    output logic [wfbm_pkg::REASON_W-1:0]     o_reason
);
    import wfbm_pkg::*;

    logic en;

    // configuration
    logic [31:0]          r_seed;
    logic [DIVISOR_W-1:0] r_map_w;
    logic [DIVISOR_W-1:0] r_map_h;
    logic [DIVISOR_W-1:0] den_x;
    logic [DIVISOR_W-1:0] den_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_map_w <= DIVISOR_W'(4096);
            r_map_h <= DIVISOR_W'(4096);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SEED:       r_seed  <= i_cfg_wdata;
                CFG_MAP_WIDTH:  r_map_w <= i_cfg_wdata[DIVISOR_W-1:0];
                CFG_MAP_HEIGHT: r_map_h <= i_cfg_wdata[DIVISOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign den_x = (r_map_w == '0) ? DIVISOR_W'(1) : r_map_w;
    assign den_y = (r_map_h == '0) ? DIVISOR_W'(1) : r_map_h;

    // early rejection rules
    t_reason early;
    logic t_lo, t_hi, m_lo, m_mid;

    always_comb begin
        t_lo  = i_temperature < CLIM_BAND1;
        t_hi  = i_temperature >= CLIM_BAND2;
        m_lo  = i_moisture < CLIM_BAND1;
        m_mid = !m_lo && (i_moisture < CLIM_BAND2);
        if (!i_land_flag) begin
            early = REASON_WATER;
        end else if (!(i_elevation inside {[ELEV_MIN:ELEV_MAX]})) begin
            early = REASON_HEIGHT;
        end else if ((t_lo && !m_mid) || (t_hi && m_lo)) begin
            early = REASON_BIOME;
        end else begin
            early = REASON_PLACED;
        end
    end

    // sideband travelling with each request
    logic                  r_sv [L_DENS+1];
    logic [COORD_BITS-1:0] r_sx [L_DENS+1];
    logic [COORD_BITS-1:0] r_sy [L_DENS+1];
    t_reason               r_sr [L_DENS+1];

    logic    r_out_valid;
    logic    r_out_spawn;
    t_reason r_out_reason;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= L_DENS; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_valid;
            for (int k = 1; k <= L_DENS; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_out_valid <= r_sv[L_DENS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx[0] <= i_cell_x;
            r_sy[0] <= i_cell_y;
            r_sr[0] <= early;
            for (int k = 1; k <= L_DENS; k++) begin
                r_sx[k] <= r_sx[k-1];
                r_sy[k] <= r_sy[k-1];
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    // normalised position
    logic [NUM_W-1:0] nx, ny;
    logic [NUM_W-1:0] r_nxd [NX_DLY];
    logic [NUM_W-1:0] r_nyd [NX_DLY];

    wfbm_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(r_sx[0]), .i_den(den_x), .o_quo(nx));
    wfbm_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(r_sy[0]), .i_den(den_y), .o_quo(ny));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nxd[0] <= nx;
            r_nyd[0] <= ny;
            for (int k = 1; k < NX_DLY; k++) begin
                r_nxd[k] <= r_nxd[k-1];
                r_nyd[k] <= r_nyd[k-1];
            end
        end
    end

    // warp fields: two 3-octave passes over the same position
    logic [NV_W-1:0] warp_nz [2][4];
    logic [NV_W-1:0] warp_q  [2];
    logic [31:0]     warp_base [2];

    assign warp_base[0] = r_seed + SEED_WARP_X;
    assign warp_base[1] = r_seed + SEED_WARP_Y;

    for (genvar w = 0; w < 2; w++) begin : g_warp
        for (genvar i = 0; i < 3; i++) begin : g_oct
            logic signed [POS_W-1:0] px, py;
            assign px = $signed(POS_W'(nx) << (WARP_SH + i));
            assign py = $signed(POS_W'(ny) << (WARP_SH + i));
            wfbm_vnoise u_vn (
                .i_clk(i_clk), .i_en(en), .i_px(px), .i_py(py),
                .i_sd(warp_base[w] + 32'(SEED_STEP * i)), .o_value(warp_nz[w][i])
            );
        end
        assign warp_nz[w][3] = '0;
        wfbm_fbm u_fbm (
            .i_clk(i_clk), .i_en(en), .i_oct(OCT_3),
            .i_noise(warp_nz[w]), .o_value(warp_q[w])
        );
    end

    // warped position
    logic signed [WX_W-1:0] r_wx [2];
    logic signed [NV_W:0]    wd   [2];
    logic signed [NV_W+13:0] wp   [2];
    logic signed [NV_W+13:0] woff [2];
    logic [NUM_W-1:0]        nbase [2];

    assign nbase[0] = r_nxd[NX_DLY-1];
    assign nbase[1] = r_nyd[NX_DLY-1];

    for (genvar w = 0; w < 2; w++) begin : g_wx
        assign wd[w]   = $signed({1'b0, warp_q[w]}) - $signed((NV_W+1)'(WARP_HALF));
        assign wp[w]   = wd[w] * $signed(14'(WARP_GAIN));
        assign woff[w] = wp[w] >>> NOISE_FRAC_BITS;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_wx[w] <= $signed({2'b00, nbase[w]}) + WX_W'(woff[w]);
            end
        end
    end

    // layer positions
    logic signed [POS_W-1:0] r_lp [2];
    logic signed [POS_W-1:0] r_mp [2];
    logic signed [POS_W-1:0] r_fp [2];
    logic signed [POS_W-1:0] wxe  [2];

    for (genvar w = 0; w < 2; w++) begin : g_scale
        assign wxe[w] = POS_W'(r_wx[w]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lp[w] <= POS_W'(wxe[w] * LAYER_LARGE);
                r_mp[w] <= POS_W'(wxe[w] * LAYER_MED);
                r_fp[w] <= POS_W'(wxe[w] * LAYER_FINE);
            end
        end
    end

    // noise layers of 4, 3 and 2 octaves
    logic [NV_W-1:0] lnz [4];
    logic [NV_W-1:0] mnz [4];
    logic [NV_W-1:0] fnz [4];
    logic [NV_W-1:0] large_q, med_q, fine_q;

    for (genvar i = 0; i < 4; i++) begin : g_large
        wfbm_vnoise u_vn (
            .i_clk(i_clk), .i_en(en),
            .i_px(r_lp[0] <<< i), .i_py(r_lp[1] <<< i),
            .i_sd(r_seed + SEED_LARGE + 32'(SEED_STEP * i)), .o_value(lnz[i])
        );
    end
    for (genvar i = 0; i < 3; i++) begin : g_med
        wfbm_vnoise u_vn (
            .i_clk(i_clk), .i_en(en),
            .i_px(r_mp[0] <<< i), .i_py(r_mp[1] <<< i),
            .i_sd(r_seed + SEED_MED + 32'(SEED_STEP * i)), .o_value(mnz[i])
        );
    end
    for (genvar i = 0; i < 2; i++) begin : g_fine
        wfbm_vnoise u_vn (
            .i_clk(i_clk), .i_en(en),
            .i_px(r_fp[0] <<< i), .i_py(r_fp[1] <<< i),
            .i_sd(r_seed + SEED_FINE + 32'(SEED_STEP * i)), .o_value(fnz[i])
        );
    end
    assign mnz[3] = '0;
    assign fnz[2] = '0;
    assign fnz[3] = '0;

    wfbm_fbm u_fbm_large (.i_clk(i_clk), .i_en(en), .i_oct(OCT_4),
                          .i_noise(lnz), .o_value(large_q));
    wfbm_fbm u_fbm_med   (.i_clk(i_clk), .i_en(en), .i_oct(OCT_3),
                          .i_noise(mnz), .o_value(med_q));
    wfbm_fbm u_fbm_fine  (.i_clk(i_clk), .i_en(en), .i_oct(OCT_2),
                          .i_noise(fnz), .o_value(fine_q));

    // mix, clamp and smoothstep density
    logic [NV_W+17:0] mix;
    logic [NV_W-1:0]  r_noise;
    logic [NV_W+2:0]  cdiff;
    logic [NV_W:0]    n_c;
    logic [NV_W:0]    r_c, r_c2, r_cd, r_dens;
    logic [2*NV_W+1:0] csq;
    logic [NV_W+1:0]   cpoly;
    logic [2*NV_W+2:0] dprod;

    assign mix = (NV_W+18)'(large_q) * (NV_W+18)'(W_LARGE)
               + (NV_W+18)'(med_q)   * (NV_W+18)'(W_MED)
               + (NV_W+18)'(fine_q)  * (NV_W+18)'(W_FINE);

    always_comb begin
        cdiff = (NV_W+3)'(r_noise - NOISE_T0) * (NV_W+3)'(5);
        if (r_noise <= NOISE_T0) begin
            n_c = '0;
        end else if (cdiff > (NV_W+3)'(NOISE_ONE)) begin
            n_c = NOISE_ONE;
        end else begin
            n_c = cdiff[NV_W:0];
        end
    end

    assign csq   = r_c * r_c;
    assign cpoly = (NV_W+2)'(NOISE_ONE) * (NV_W+2)'(3) - {r_cd, 1'b0};
    assign dprod = r_c2 * cpoly;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_noise <= mix[MIX_SHIFT +: NV_W];
            r_c     <= n_c;
            r_c2    <= csq[NOISE_FRAC_BITS +: NV_W+1];
            r_cd    <= r_c;
            r_dens  <= dprod[NOISE_FRAC_BITS +: NV_W+1];
        end
    end

    // per-cell placement hash
    logic [31:0] rnd;

    wfbm_hash u_place (
        .i_clk(i_clk), .i_en(en),
        .i_x(32'(r_sx[L_DENS-HASH_LAT])), .i_y(32'(r_sy[L_DENS-HASH_LAT])),
        .i_sd(r_seed + SEED_PLACE), .o_hash(rnd)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sr[L_DENS] != REASON_PLACED) begin
                r_out_spawn  <= 1'b0;
                r_out_reason <= r_sr[L_DENS];
            end else if ({1'b0, rnd} < {r_dens, {(32-NOISE_FRAC_BITS){1'b0}}}) begin
                r_out_spawn  <= 1'b1;
                r_out_reason <= REASON_PLACED;
            end else begin
                r_out_spawn  <= 1'b0;
                r_out_reason <= REASON_DENSITY;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_spawn_tree = r_out_spawn;
    assign o_reason     = r_out_reason;

endmodule

// ===== hdl/wfbm_checker.sv =====
// Port-level checks for the tree placement block, bound to the top level
`include "assert_macros.svh"

module wfbm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_spawn_tree,
    input logic [wfbm_pkg::REASON_W-1:0] o_reason
);
    import wfbm_pkg::*;

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_spawn_tree) && $stable(o_reason))
    `ASSERT_CLK(a_spawn_code, i_clk, i_rst_n, o_valid |-> (o_spawn_tree == (o_reason == REASON_PLACED)))
    `ASSERT_NEVER(a_reason_range, i_clk, i_rst_n, o_valid && (o_reason > REASON_DENSITY))
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready)

endmodule

bind warped_fbm_tree_placement wfbm_checker u_wfbm_checker (.*);

// ===== sim/warped_fbm_tree_placement_chk.sv =====
// Checker for the tree placement block: predicts each cell result and compares it
module warped_fbm_tree_placement_chk
    import wfbm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_valid,
    input  logic                    i_ready_in,
    input  logic [COORD_BITS-1:0]   i_cell_x,
    input  logic [COORD_BITS-1:0]   i_cell_y,
    input  logic [BYTE_W-1:0]       i_elevation,
    input  logic [BYTE_W-1:0]       i_moisture,
    input  logic [BYTE_W-1:0]       i_temperature,
    input  logic                    i_land_flag,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_spawn_tree,
    input  logic [REASON_W-1:0]     i_reason,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic    spawn;
        t_reason reason;
    } t_placement;

    logic [31:0] cur_seed;
    logic [12:0] cur_width;
    logic [12:0] cur_height;
    t_placement  placement_q[$];

    function automatic logic [31:0] cell_hash(logic [31:0] x, logic [31:0] y, logic [31:0] sd);
        logic [31:0] v;
        v = x * HASH_KX + y * HASH_KY + sd * HASH_KS;
        v = (v ^ (v >> 13)) * HASH_KM;
        return v ^ (v >> 16);
    endfunction

    function automatic longint fl_shift(longint v, int n);
        longint one_n;
        one_n = longint'(1) << n;
        if (v >= 0) return v >>> n;
        return -((-v + one_n - 1) >>> n);
    endfunction

    function automatic longint smooth16(longint f);
        longint f2;
        f2 = (f * f) >>> 16;
        return (f2 * (3 * 65536 - 2 * f)) >>> 16;
    endfunction

    function automatic longint blend16(longint a, longint b, longint s);
        return (a * (65536 - s) + b * s) >>> 16;
    endfunction

    function automatic longint corner(longint ix, longint iy, logic [31:0] sd);
        return longint'(cell_hash(ix[31:0], iy[31:0], sd) >> (32 - NOISE_FRAC_BITS));
    endfunction

    function automatic longint vnoise(longint px, longint py, logic [31:0] sd);
        longint ix, iy, sx, sy, a, b;
        ix = fl_shift(px, 16);
        iy = fl_shift(py, 16);
        sx = smooth16(px - ix * 65536);
        sy = smooth16(py - iy * 65536);
        a = blend16(corner(ix, iy, sd), corner(ix + 1, iy, sd), sx);
        b = blend16(corner(ix, iy + 1, sd), corner(ix + 1, iy + 1, sd), sx);
        return blend16(a, b, sy);
    endfunction

    function automatic longint fbm(longint px, longint py, logic [31:0] sd, int octaves);
        longint acc;
        acc = 0;
        for (int i = 0; i < octaves; i++)
            acc += vnoise(px << i, py << i, sd + 32'(100 * i)) << (octaves - 1 - i);
        return acc / ((longint'(1) << octaves) - 1);
    endfunction

    function automatic longint warp_shift(longint w);
        return fl_shift((w - WARP_HALF) * WARP_GAIN, NOISE_FRAC_BITS);
    endfunction

    function automatic t_placement place_cell(logic [11:0] x, logic [11:0] y,
                                              logic [7:0] elev, logic [7:0] moist,
                                              logic [7:0] temp, logic land);
        t_placement r;
        int trow, mcol;
        longint mw, mh, nx, ny, wx, wy, lg, md, fn, nse, t0, c, dens, one;
        logic [31:0] rnd;
        one = longint'(1) << NOISE_FRAC_BITS;
        r.spawn = 1'b0;
        if (!land) begin
            r.reason = REASON_WATER;
            return r;
        end
        if (elev <= 109 || elev >= 205) begin
            r.reason = REASON_HEIGHT;
            return r;
        end
        trow = temp / 86;
        if (trow > 2) trow = 2;
        mcol = moist / 86;
        if (mcol > 2) mcol = 2;
        if ((trow == 0 && mcol != 1) || (trow == 2 && mcol == 0)) begin
            r.reason = REASON_BIOME;
            return r;
        end
        mw = (cur_width == 0) ? 1 : longint'(cur_width);
        mh = (cur_height == 0) ? 1 : longint'(cur_height);
        nx = (longint'(x) << 16) / mw;
        ny = (longint'(y) << 16) / mh;
        wx = nx + warp_shift(fbm(nx * 8, ny * 8, cur_seed + SEED_WARP_X, 3));
        wy = ny + warp_shift(fbm(nx * 8, ny * 8, cur_seed + SEED_WARP_Y, 3));
        lg = fbm(wx * 14, wy * 14, cur_seed + SEED_LARGE, 4);
        md = fbm(wx * 35, wy * 35, cur_seed + SEED_MED, 3);
        fn = fbm(wx * 70, wy * 70, cur_seed + SEED_FINE, 2);
        nse = (lg * 26214 + md * 22938 + fn * 16384) >>> 16;
        t0 = (7 * one) / 20;
        if (nse <= t0) c = 0;
        else begin
            c = (nse - t0) * 5;
            if (c > one) c = one;
        end
        dens = (((c * c) >>> NOISE_FRAC_BITS) * (3 * one - 2 * c)) >>> NOISE_FRAC_BITS;
        rnd = cell_hash(32'(x), 32'(y), cur_seed + SEED_PLACE);
        if (longint'(rnd) < (dens << (32 - NOISE_FRAC_BITS))) begin
            r.spawn = 1'b1;
            r.reason = REASON_PLACED;
        end else begin
            r.reason = REASON_DENSITY;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = placement_q.size();

    always @(posedge i_clk) begin
        t_placement exp_r;
        if (!i_rst_n) begin
            cur_seed   <= '0;
            cur_width  <= 13'd4096;
            cur_height <= 13'd4096;
            placement_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SEED:       cur_seed   <= i_cfg_wdata;
                    CFG_MAP_WIDTH:  cur_width  <= i_cfg_wdata[12:0];
                    CFG_MAP_HEIGHT: cur_height <= i_cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in)
                placement_q.insert(placement_q.size(),
                                   place_cell(i_cell_x, i_cell_y, i_elevation,
                                              i_moisture, i_temperature, i_land_flag));
            if (i_out_valid && i_out_ready) begin
                if (placement_q.size() == 0) begin
                    report_mismatch("result with no request waiting");
                end else begin
                    exp_r = placement_q.pop_front();
                    if (i_spawn_tree !== exp_r.spawn)
                        report_mismatch($sformatf("spawn_tree %b, want %b",
                                                  i_spawn_tree, exp_r.spawn));
                    if (i_reason !== exp_r.reason)
                        report_mismatch($sformatf("reason %0d, want %0d",
                                                  i_reason, exp_r.reason));
                end
            end
        end
    end
endmodule

// ===== sim/warped_fbm_tree_placement_tb.sv =====
// Testbench top: drives cell requests and configuration, gives the verdict
module warped_fbm_tree_placement_tb;
    import wfbm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [COORD_BITS-1:0] i_cell_x, i_cell_y;
    logic [BYTE_W-1:0]     i_elevation, i_moisture, i_temperature;
    logic                  i_land_flag;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_spawn_tree;
    logic [REASON_W-1:0]   o_reason;
    int                    fail_count;
    int                    pending;
    int                    cycles;
    bit                    idle_free;
    bit                    hold_off;

    warped_fbm_tree_placement dut (.*);

    warped_fbm_tree_placement_chk u_chk (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_idx, .i_cfg_wdata,
        .i_valid, .i_ready_in(o_ready),
        .i_cell_x, .i_cell_y, .i_elevation, .i_moisture, .i_temperature, .i_land_flag,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_spawn_tree(o_spawn_tree), .i_reason(o_reason),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, none during the clean stretch, all during the hold-off
    always @(posedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else if (idle_free) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 38);
    end

    // hold the write enable high; end_config drops it after the last write
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic end_config;
        i_cfg_wr_en <= 1'b0;
    endtask

    // valid stays high after acceptance; the next idle cycle or drain drops it
    task automatic send_cell(logic [11:0] x, logic [11:0] y, logic [7:0] e,
                             logic [7:0] m, logic [7:0] t, logic l);
        while (!idle_free && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cell_x      <= x;
        i_cell_y      <= y;
        i_elevation   <= e;
        i_moisture    <= m;
        i_temperature <= t;
        i_land_flag   <= l;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
    endtask

    // mostly cells that pass the early rejects, some of any shape
    task automatic random_cell(int w, int h);
        logic [11:0] x, y;
        logic [7:0] e, m, t;
        logic l;
        x = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(w - 1));
        y = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(h - 1));
        if ($urandom_range(99) < 75) begin
            e = 8'($urandom_range(204, 110));
            t = 8'($urandom_range(255, 86));
            m = (t >= 172) ? 8'($urandom_range(255, 86)) : 8'($urandom);
            l = 1'b1;
        end else begin
            e = 8'($urandom);
            m = 8'($urandom);
            t = 8'($urandom);
            l = 1'($urandom);
        end
        send_cell(x, y, e, m, t, l);
    endtask

    initial begin
        int w, h;
        cycles = 0;
        idle_free = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = CFG_SEED;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cell_x = '0;
        i_cell_y = '0;
        i_elevation = '0;
        i_moisture = '0;
        i_temperature = '0;
        i_land_flag = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, extremes, each reject and band edge
        send_cell(12'd0, 12'd0, 8'd150, 8'd100, 8'd100, 1'b0);
        send_cell(12'hFFF, 12'hFFF, 8'd109, 8'd100, 8'd100, 1'b1);
        send_cell(12'd5, 12'd5, 8'd110, 8'd100, 8'd100, 1'b1);
        send_cell(12'd5, 12'd5, 8'd204, 8'd100, 8'd100, 1'b1);
        send_cell(12'd5, 12'd5, 8'd205, 8'd100, 8'd100, 1'b1);
        send_cell(12'd5, 12'd5, 8'd0, 8'd0, 8'd0, 1'b1);
        send_cell(12'd5, 12'd5, 8'd255, 8'd255, 8'd255, 1'b1);
        send_cell(12'd9, 12'd9, 8'd150, 8'd85, 8'd85, 1'b1);
        send_cell(12'd9, 12'd9, 8'd150, 8'd86, 8'd85, 1'b1);
        send_cell(12'd9, 12'd9, 8'd150, 8'd172, 8'd0, 1'b1);
        send_cell(12'd9, 12'd9, 8'd150, 8'd0, 8'd171, 1'b1);
        send_cell(12'd9, 12'd9, 8'd150, 8'd85, 8'd172, 1'b1);
        send_cell(12'd9, 12'd9, 8'd150, 8'd86, 8'd255, 1'b1);
        send_cell(12'hFFF, 12'd0, 8'd150, 8'd255, 8'd200, 1'b1);
        send_cell(12'd0, 12'hFFF, 8'd150, 8'd255, 8'd200, 1'b1);
        drain();

        // beyond-map cells, a zero map width and a map height of one, wide seed
        write_reg(CFG_SEED, 32'hFFFF_FFFF);
        write_reg(CFG_MAP_WIDTH, 32'd0);
        write_reg(CFG_MAP_HEIGHT, 32'd1);
        end_config();
        send_cell(12'd0, 12'd0, 8'd150, 8'd150, 8'd150, 1'b1);
        send_cell(12'hFFF, 12'hFFF, 8'd150, 8'd150, 8'd150, 1'b1);
        send_cell(12'd3, 12'd1, 8'd180, 8'd200, 8'd120, 1'b1);
        drain();

        // random phases across several settings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin w = 4096; h = 4096; end
                1: begin w = 1; h = 1; end
                2: begin w = 64; h = 48; end
                default: begin w = $urandom_range(4096, 1); h = $urandom_range(4096, 1); end
            endcase
            write_reg(CFG_SEED, (phase == 1) ? 32'd0 : $urandom);
            write_reg(CFG_MAP_WIDTH, 32'(w));
            write_reg(CFG_MAP_HEIGHT, 32'(h));
            end_config();
            idle_free = (phase == 2);
            for (int n = 0; n < 270; n++) begin
                if (phase == 3 && n == 20) begin
                    // stall the result side while requests keep coming
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (150) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                random_cell(w, h);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
